@@ rtl/core/three_stacks_one_array_core_macros.svh @@
// assertion macros for the stack core
`ifndef THREE_STACKS_ONE_ARRAY_CORE_MACROS_SVH
`define THREE_STACKS_ONE_ARRAY_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TSOA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tsoa assertion failed");
`define TSOA_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);
`else
`define TSOA_ASSERT(lbl, clk, rst, prop)
`define TSOA_ASSERT_MSG(lbl, clk, rst, prop, msg)
`endif

`endif

@@ rtl/core/tsoa_pkg.sv @@
package tsoa_pkg;

   localparam int DATA_W         = 32;
   localparam int PART_DEPTH_DEF = 16;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] RSP_DONE  = 2'd0;
   localparam logic [1:0] RSP_FULL  = 2'd1;
   localparam logic [1:0] RSP_EMPTY = 2'd2;

   typedef struct packed {
      logic                     req_type;
      logic [1:0]               stack_sel;
      logic signed [DATA_W-1:0] push_value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] pop_value;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

@@ rtl/core/tsoa_ctrl.sv @@
module tsoa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tsoa_pkg::stat_type stat,
   output tsoa_pkg::cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.exec    = 1'b0;
      cmd.load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // wait for the result register to drain
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/tsoa_dp.sv @@
`include "three_stacks_one_array_core_macros.svh"

module tsoa_dp #(
   parameter int PART_DEPTH = tsoa_pkg::PART_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tsoa_pkg::req_word_type req_word,
   input  tsoa_pkg::cmd_type      cmd,
   output tsoa_pkg::stat_type     stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tsoa_pkg::rsp_word_type rsp_word
);

   localparam int STORE_WORDS = 3 * PART_DEPTH;
   localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int CNT_W       = $clog2(PART_DEPTH + 1);
   localparam int DW          = tsoa_pkg::DATA_W;

   localparam logic [ADDR_W-1:0] TOP_ONE   = ADDR_W'(PART_DEPTH - 1);
   localparam logic [ADDR_W-1:0] BASE_TWO  = ADDR_W'(PART_DEPTH);
   localparam logic [ADDR_W-1:0] BASE_THR  = ADDR_W'(2 * PART_DEPTH);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(PART_DEPTH);

   logic [DW-1:0] mem [STORE_WORDS];

   // captured request
   logic          op_ff;
   logic [1:0]    sel_ff;
   logic [DW-1:0] val_ff;

   logic [CNT_W-1:0] fill_ff [3];

   logic [1:0]    stat_ff;
   logic          pop_ok_ff;
   logic [DW-1:0] rdata_ff;

   logic                   rsp_valid_ff;
   tsoa_pkg::rsp_word_type rsp_ff;

   logic [CNT_W-1:0]  fill_cur;
   logic [CNT_W-1:0]  pos;
   logic [ADDR_W-1:0] addr;
   logic              is_full;
   logic              is_empty;
   logic              push_ok;
   logic              pop_ok;
   logic [1:0]        stat_in;

   always_comb begin
      unique case (sel_ff)
         2'd0:    fill_cur = fill_ff[0];
         2'd1:    fill_cur = fill_ff[1];
         default: fill_cur = fill_ff[2];
      endcase
      is_full  = (fill_cur == FULL_CNT);
      is_empty = (fill_cur == '0);
      push_ok  = (op_ff == tsoa_pkg::OP_PUSH) && !is_full;
      pop_ok   = (op_ff == tsoa_pkg::OP_POP) && !is_empty;
      pos      = (op_ff == tsoa_pkg::OP_PUSH) ? fill_cur : fill_cur - CNT_W'(1);
      // stack one grows down from the top of its partition
      unique case (sel_ff)
         2'd0:    addr = TOP_ONE - ADDR_W'(pos);
         2'd1:    addr = BASE_TWO + ADDR_W'(pos);
         default: addr = BASE_THR + ADDR_W'(pos);
      endcase
      if (op_ff == tsoa_pkg::OP_PUSH) begin
         stat_in = is_full ? tsoa_pkg::RSP_FULL : tsoa_pkg::RSP_DONE;
      end else begin
         stat_in = is_empty ? tsoa_pkg::RSP_EMPTY : tsoa_pkg::RSP_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_word.req_type;
         sel_ff <= (req_word.stack_sel == 2'd3) ? 2'd2 : req_word.stack_sel;
         val_ff <= req_word.push_value;
      end
      if (cmd.exec) begin
         stat_ff   <= stat_in;
         pop_ok_ff <= pop_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && push_ok) begin
         mem[addr] <= val_ff;
      end
      if (cmd.exec && pop_ok) begin
         rdata_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff[0] <= '0;
         fill_ff[1] <= '0;
         fill_ff[2] <= '0;
      end else if (cmd.exec) begin
         if (push_ok) begin
            fill_ff[sel_ff] <= fill_cur + CNT_W'(1);
         end else if (pop_ok) begin
            fill_ff[sel_ff] <= fill_cur - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.status    <= stat_ff;
         rsp_ff.pop_value <= pop_ok_ff ? rdata_ff : '0;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_ff;

   `TSOA_ASSERT_MSG(a_fill_bound, clock, reset, fill_ff[0] <= FULL_CNT && fill_ff[1] <= FULL_CNT && fill_ff[2] <= FULL_CNT, "stack count beyond partition")
   `TSOA_ASSERT(a_fill_only_exec, clock, reset, !cmd.exec |=> $stable(fill_ff[0]) && $stable(fill_ff[1]) && $stable(fill_ff[2]))
   `TSOA_ASSERT_MSG(a_refused_zero, clock, reset, rsp_valid_ff && rsp_ff.status != tsoa_pkg::RSP_DONE |-> rsp_ff.pop_value == '0, "refused word carries data")
   `TSOA_ASSERT(a_load_free, clock, reset, cmd.load |-> stat.out_free)

endmodule

@@ rtl/core/three_stacks_one_array_core.sv @@
// requests go through capture, execute with memory access and load result, one at a time
// the load step stalls while the result register still holds a result that rsp_ready has not taken
// a new request is taken while a result waits
// reset: synchronous, active high; clears stack counts and the result valid, no memory sweep
module three_stacks_one_array_core #(
   parameter int PART_DEPTH = tsoa_pkg::PART_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tsoa_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tsoa_pkg::rsp_word_type rsp_word
);

   tsoa_pkg::cmd_type  cmd;
   tsoa_pkg::stat_type stat;

   tsoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tsoa_dp #(
      .PART_DEPTH (PART_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

@@ tb/tb_three_stacks_one_array_core.sv @@
`timescale 1ns / 100ps

module tb_three_stacks_one_array_core;
   import tsoa_pkg::*;

   localparam int PART_DEPTH = PART_DEPTH_DEF;
   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 24;
   localparam int MIX_WORDS = 1100;
   localparam logic [1:0] SEL_FIRST = 2'd0;
   localparam logic [1:0] SEL_SECOND = 2'd1;
   localparam logic [1:0] SEL_THIRD = 2'd2;
   localparam logic [1:0] SEL_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   // shadow of the three stacks
   logic signed [DATA_W-1:0] shadow_stack [3][PART_DEPTH];
   int unsigned shadow_fill [3];
   rsp_word_type awaited_rsp_q [$];

   int error_count = 0;
   int quiet_cycles = 0;
   bit sender_paced = 1'b1;
   int burst_left = 0;
   int rsp_mode = 0;
   int rsp_mode_left = 0;
   int rsp_tick = 0;

   three_stacks_one_array_core #(
      .PART_DEPTH(PART_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #4 clock = ~clock;

   function automatic rsp_word_type stack_outcome(input req_word_type w);
      int unsigned s;
      rsp_word_type r;
      s = (w.stack_sel == SEL_SPARE) ? 2 : w.stack_sel;
      r.status = RSP_DONE;
      r.pop_value = '0;
      if (w.req_type == OP_PUSH) begin
         if (shadow_fill[s] >= PART_DEPTH) begin
            r.status = RSP_FULL;
         end else begin
            shadow_stack[s][shadow_fill[s]] = w.push_value;
            shadow_fill[s]++;
         end
      end else begin
         if (shadow_fill[s] == 0) begin
            r.status = RSP_EMPTY;
         end else begin
            shadow_fill[s]--;
            r.pop_value = shadow_stack[s][shadow_fill[s]];
         end
      end
      return r;
   endfunction

   function automatic req_word_type make_req(input logic op, input logic [1:0] sel,
                                             input logic [DATA_W-1:0] val);
      req_word_type w;
      w.req_type = op;
      w.stack_sel = sel;
      w.push_value = val;
      return w;
   endfunction

   task automatic hold_off(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // valid is left high on return so back-to-back words need no extra edge
   task automatic send_req(input req_word_type w);
      int gap;
      if (sender_paced) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) hold_off(gap);
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      awaited_rsp_q.push_back(stack_outcome(w));
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (awaited_rsp_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [1:0] pick_sel();
      logic [1:0] sel;
      sel = 2'($urandom_range(0, 2));
      if (sel == SEL_THIRD && $urandom_range(0, 2) == 0) sel = SEL_SPARE;
      return sel;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_pops();
      send_req(make_req(OP_POP, SEL_FIRST, 32'h0));
      send_req(make_req(OP_POP, SEL_SECOND, 32'hffff_ffff));
      send_req(make_req(OP_POP, SEL_THIRD, 32'h0));
      send_req(make_req(OP_POP, SEL_SPARE, 32'h1234_5678));
   endtask

   task automatic test_extreme_values();
      send_req(make_req(OP_PUSH, SEL_FIRST, 32'h7fff_ffff));
      send_req(make_req(OP_PUSH, SEL_FIRST, 32'h0000_0000));
      send_req(make_req(OP_PUSH, SEL_SECOND, 32'h8000_0000));
      send_req(make_req(OP_PUSH, SEL_SPARE, 32'hffff_ffff));
      send_req(make_req(OP_PUSH, SEL_THIRD, 32'haaaa_aaaa));
      send_req(make_req(OP_PUSH, SEL_SECOND, 32'h5555_5555));
      send_req(make_req(OP_POP, SEL_FIRST, 32'h0));
      send_req(make_req(OP_POP, SEL_FIRST, 32'h0));
      send_req(make_req(OP_POP, SEL_SECOND, 32'h0));
      send_req(make_req(OP_POP, SEL_SPARE, 32'h0));
      send_req(make_req(OP_POP, SEL_THIRD, 32'h0));
      send_req(make_req(OP_POP, SEL_SECOND, 32'h0));
      send_req(make_req(OP_POP, SEL_SECOND, 32'h0));
   endtask

   // fill each stack past full, then drain past empty
   task automatic test_fill_and_drain();
      logic [1:0] sel;
      for (int s = 0; s < 3; s++) begin
         for (int k = 0; k <= PART_DEPTH; k++) begin
            sel = (s == 2 && $urandom_range(0, 1)) ? SEL_SPARE : 2'(s);
            send_req(make_req(OP_PUSH, sel, pick_value()));
         end
      end
      // push onto the full second stack, pop once, then push twice: refill, then full again
      send_req(make_req(OP_PUSH, SEL_SECOND, $urandom));
      send_req(make_req(OP_POP, SEL_SECOND, 32'h0));
      send_req(make_req(OP_PUSH, SEL_SECOND, $urandom));
      send_req(make_req(OP_PUSH, SEL_SECOND, $urandom));
      for (int s = 2; s >= 0; s--) begin
         for (int k = 0; k <= PART_DEPTH; k++) begin
            sel = (s == 2 && $urandom_range(0, 1)) ? SEL_SPARE : 2'(s);
            send_req(make_req(OP_POP, sel, $urandom));
         end
      end
   endtask

   task automatic test_random_mix();
      int push_pct;
      int phase_left;
      req_word_type w;
      push_pct = 50;
      phase_left = 0;
      for (int n = 0; n < MIX_WORDS; n++) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 3))
               0: push_pct = 85;
               1: push_pct = 15;
               default: push_pct = 50;
            endcase
            phase_left = $urandom_range(30, 120);
            sender_paced = ($urandom_range(0, 3) != 0);
         end
         phase_left--;
         if ($urandom_range(0, 9) == 0) begin
            w = make_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom);
         end else begin
            w = make_req(($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP,
                         pick_sel(), pick_value());
         end
         send_req(w);
         if (n == MIX_WORDS / 2) wait_results_drained();
      end
      sender_paced = 1'b1;
   endtask

   // receiver stall pattern: always ready, coin flip, or a fixed 4-of-7 duty
   always @(posedge clock) begin
      rsp_tick <= rsp_tick + 1;
      if (rsp_mode_left == 0) begin
         rsp_mode <= $urandom_range(0, 2);
         rsp_mode_left <= $urandom_range(30, 200);
      end else begin
         rsp_mode_left <= rsp_mode_left - 1;
      end
      case (rsp_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= (rsp_tick % 7) < 4;
      endcase
   end

   always @(posedge clock) begin
      rsp_word_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp_q.size() == 0) begin
            $error("unexpected result word: status %0d, pop_value %0d",
                   rsp_word.status, rsp_word.pop_value);
            error_count++;
         end else begin
            exp_rsp = awaited_rsp_q.pop_front();
            if (rsp_word.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.pop_value !== exp_rsp.pop_value) begin
               $error("pop_value: expected %0d, got %0d",
                      exp_rsp.pop_value, rsp_word.pop_value);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_pops();
      test_extreme_values();
      wait_results_drained();
      test_fill_and_drain();
      wait_results_drained();
      test_random_mix();
      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited_rsp_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ three_stacks_one_array_core.f @@
+incdir+rtl/core
rtl/core/tsoa_pkg.sv
rtl/core/tsoa_ctrl.sv
rtl/core/tsoa_dp.sv
rtl/core/three_stacks_one_array_core.sv
tb/tb_three_stacks_one_array_core.sv
